@@ hw/rtl/wsp_pkg.sv @@
// Shared types, constants and codes for the wheel sync proportional controller.
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

    // Timing and encoder correction
    localparam int CYCLE_MS       = 5;
    localparam int CORRECTION_DIV = 50;

    // Field widths
    localparam int COUNT_W    = 24;
    localparam int RC_W       = COUNT_W + 1;
    localparam int ERR_W      = 27;
    localparam int CNT_W      = 20;
    localparam int ELAPSED_W  = CNT_W + $clog2(CYCLE_MS + 1);
    localparam int SPEED_W    = 8;
    localparam int DRIVE_W    = 8;
    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 20;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam int               DRIVE_MAX = 100;

    // Reciprocal for r / CORRECTION_DIV, exact for every 24-bit magnitude
    localparam int CORR_SHIFT = COUNT_W + $clog2(CORRECTION_DIV);
    localparam int CORR_MUL_W = COUNT_W + 1;
    localparam int CORR_PROD_W = COUNT_W + CORR_MUL_W;
    localparam longint unsigned CORR_MUL_L =
        ((64'd1 << CORR_SHIFT) + CORRECTION_DIV - 1) / CORRECTION_DIV;
    localparam logic [CORR_MUL_W-1:0] CORR_MUL = CORR_MUL_W'(CORR_MUL_L);

    // Item function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Stop rule codes
    localparam logic [MODE_W-1:0] MODE_TICKS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME_BUMP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIME      = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUMP_RELEASE = 3'd5;

    typedef struct packed {
        logic                      func;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [COUNT_W-1:0] right_count;
        logic [LEVEL_W-1:0]        bump_level;
    } item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      running;
    } result_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic [MODE_W-1:0]         drive_mode;
        logic [LIMIT_W-1:0]        stop_limit;
        logic [GAIN_W-1:0]         trim_gain;
        logic [LEVEL_W-1:0]        bump_release_level;
    } cfg_t;

    // Registered input word with the corrected right count
    typedef struct packed {
        logic                      valid;
        logic                      func;
        logic signed [COUNT_W-1:0] left_count;
        logic signed [RC_W-1:0]    right_corr;
        logic [LEVEL_W-1:0]        bump_level;
    } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/wheel_sync_p_controller.sv @@
// Top level of the wheel sync proportional controller.
// An accepted item word passes the input register in wsp_front, then the result register in wsp_core.
// Throughput: one item word per cycle while result_ready is high.
// A stalled output holds one word in the result register; item_ready follows result_ready combinationally.
// Reset (rst_n low, async) clears state, empties the pipeline, and loads
// register defaults; the block starts stopped until a start word arrives.
`timescale 1ns / 1ps
`default_nettype none

module wheel_sync_p_controller
    import wsp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  item_t                      item_data,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    // result register can take a new word
    assign advance = !result_valid || result_ready;

    wsp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .advance    (advance),
        .stage      (stage)
    );

    wsp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .stage        (stage),
        .advance      (advance),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/wsp_cfg_regs.sv @@
// Configuration register file for the wheel sync controller.
`timescale 1ns / 1ps
`default_nettype none

module wsp_cfg_regs
    import wsp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_speed         <= SPEED_W'(50);
            cfg_reg.right_speed        <= SPEED_W'(50);
            cfg_reg.drive_mode         <= MODE_TICKS;
            cfg_reg.stop_limit         <= '0;
            cfg_reg.trim_gain          <= GAIN_W'(19661);
            cfg_reg.bump_release_level <= LEVEL_W'(400);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEFT_SPEED:   cfg_reg.left_speed         <= cfg_data[SPEED_W-1:0];
                REG_RIGHT_SPEED:  cfg_reg.right_speed        <= cfg_data[SPEED_W-1:0];
                REG_DRIVE_MODE:   cfg_reg.drive_mode         <= cfg_data[MODE_W-1:0];
                REG_STOP_LIMIT:   cfg_reg.stop_limit         <= cfg_data[LIMIT_W-1:0];
                REG_TRIM_GAIN:    cfg_reg.trim_gain          <= cfg_data[GAIN_W-1:0];
                REG_BUMP_RELEASE: cfg_reg.bump_release_level <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/wsp_front.sv @@
// Input register stage: takes an item word and corrects the right count.
`timescale 1ns / 1ps
`default_nettype none

module wsp_front
    import wsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_ready,
    input  item_t      item_data,
    input  wire logic  advance,
    output stage_t     stage
);

    logic                     valid_reg;
    stage_t                   data_reg;
    logic                     r_neg;
    logic [COUNT_W-1:0]       r_mag;
    logic [CORR_PROD_W-1:0]   corr_prod;
    logic [COUNT_W-1:0]       quot;
    logic [RC_W-1:0]          quot_ext;
    logic signed [RC_W-1:0]   right_corr;
    logic                     load;

    // r + r/DIV, quotient truncated toward zero via magnitude
    always_comb
    begin
        r_neg      = item_data.right_count[COUNT_W-1];
        r_mag      = r_neg ? COUNT_W'(~item_data.right_count + 1'b1)
                           : COUNT_W'(item_data.right_count);
        corr_prod  = CORR_PROD_W'(r_mag) * CORR_PROD_W'(CORR_MUL);
        quot       = COUNT_W'(corr_prod >> CORR_SHIFT);
        quot_ext   = RC_W'(quot);
        right_corr = RC_W'(item_data.right_count)
                   + (r_neg ? RC_W'(~quot_ext + 1'b1) : quot_ext);
    end

    assign item_ready = !valid_reg || advance;
    assign load       = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.valid      <= 1'b1;
            data_reg.func       <= item_data.func;
            data_reg.left_count <= item_data.left_count;
            data_reg.right_corr <= right_corr;
            data_reg.bump_level <= item_data.bump_level;
        end
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/wsp_core.sv @@
// Controller state, error and trim datapath, stop test and result register.
`timescale 1ns / 1ps
`default_nettype none

module wsp_core
    import wsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  stage_t    stage,
    input  wire logic advance,
    output logic      result_valid,
    output result_t   result_data
);

    localparam int TRIM_W = ERR_W + GAIN_W + 1;
    localparam int SUM_W  = TRIM_W + 1;
    localparam int Q_W    = SUM_W - GAIN_FRAC;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(DRIVE_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(DRIVE_MAX);

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [Q_W-1:0] v
    );
        logic signed [DRIVE_W-1:0] r;
        if (v > Q_MAX)
            r = DRIVE_W'(DRIVE_MAX);
        else if (v < Q_MIN)
            r = -DRIVE_W'(DRIVE_MAX);
        else
            r = DRIVE_W'(v);
        return r;
    endfunction

    logic signed [RC_W-1:0]  start_left_reg;
    logic signed [RC_W-1:0]  start_right_reg;
    logic [CNT_W-1:0]        cycle_count_reg;
    logic                    active_reg;
    logic                    result_valid_reg;
    result_t                 result_data_reg;

    logic                    step;
    logic                    is_start;
    logic                    do_update;
    logic signed [ERR_W-1:0] dl;
    logic signed [ERR_W-1:0] dr;
    logic signed [ERR_W-1:0] err_now;
    logic [CNT_W-1:0]        cycle_count_next;
    logic [ELAPSED_W-1:0]    elapsed;
    logic [RC_W-1:0]         abs_rc;
    logic                    tick_ok;
    logic                    time_ok;
    logic                    bump_ok;
    logic                    run_next;
    logic signed [GAIN_W:0]  gain_s;
    logic signed [TRIM_W-1:0] trim_prod;
    logic signed [SUM_W-1:0] sum;
    logic                    round_up;
    logic signed [Q_W-1:0]   q;
    result_t                 result_next;

    assign step      = stage.valid && advance;
    assign is_start  = (stage.func == FUNC_START);
    assign do_update = is_start || active_reg;

    always_comb
    begin
        dl = ERR_W'(stage.left_count) - ERR_W'(start_left_reg);
        dr = ERR_W'(stage.right_corr) - ERR_W'(start_right_reg);
        if (is_start)
            err_now = '0;
        else if (dl > 0 && dr > 0)
            err_now = dl - dr;
        else if (dl < 0 && dr < 0)
            err_now = dr - dl;
        else
            err_now = -(dl + dr);

        if (is_start)
            cycle_count_next = '0;
        else if (cycle_count_reg == CNT_MAX)
            cycle_count_next = cycle_count_reg;
        else
            cycle_count_next = cycle_count_reg + 1'b1;

        elapsed = ELAPSED_W'(cycle_count_next) * ELAPSED_W'(CYCLE_MS);
        abs_rc  = stage.right_corr[RC_W-1] ? RC_W'(-stage.right_corr)
                                           : RC_W'(stage.right_corr);
        tick_ok = abs_rc < RC_W'(cfg.stop_limit);
        time_ok = elapsed < ELAPSED_W'(cfg.stop_limit);
        bump_ok = stage.bump_level > cfg.bump_release_level;

        unique case (cfg.drive_mode)
            MODE_TICKS:     run_next = tick_ok;
            MODE_TIME_BUMP: run_next = time_ok && bump_ok;
            default:        run_next = time_ok;
        endcase

        // right_speed + err*gain in Q16, truncated toward zero
        gain_s    = $signed({1'b0, cfg.trim_gain});
        trim_prod = TRIM_W'(err_now) * TRIM_W'(gain_s);
        sum       = SUM_W'(trim_prod) + (SUM_W'(cfg.right_speed) <<< GAIN_FRAC);
        round_up  = sum[SUM_W-1] && (sum[GAIN_FRAC-1:0] != '0);
        q         = $signed(sum[SUM_W-1:GAIN_FRAC]) + Q_W'(round_up);

        if (do_update && run_next)
        begin
            result_next.left_drive  = sat_drive(Q_W'(cfg.left_speed));
            result_next.right_drive = sat_drive(q);
            result_next.running     = 1'b1;
        end
        else
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_left_reg   <= '0;
            start_right_reg  <= '0;
            cycle_count_reg  <= '0;
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= stage.valid;
            end
            if (step && do_update)
            begin
                cycle_count_reg <= cycle_count_next;
                active_reg      <= run_next;
                if (is_start)
                begin
                    start_left_reg  <= RC_W'(stage.left_count);
                    start_right_reg <= stage.right_corr;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_data_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_data_reg.running
        |-> result_data_reg.left_drive == '0 && result_data_reg.right_drive == '0)
        else $error("stopped word carries nonzero drive");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg
        |-> result_data_reg.right_drive <= DRIVE_W'(DRIVE_MAX)
            && result_data_reg.right_drive >= -DRIVE_W'(DRIVE_MAX)
            && result_data_reg.left_drive <= DRIVE_W'(DRIVE_MAX)
            && result_data_reg.left_drive >= -DRIVE_W'(DRIVE_MAX))
        else $error("drive out of range");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && stage.func == FUNC_START |=> cycle_count_reg == '0)
        else $error("start did not clear cycle count");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && stage.func == FUNC_SAMPLE && !active_reg
        |=> $stable(cycle_count_reg) && !active_reg && !result_data_reg.running)
        else $error("sample while stopped changed state");

endmodule

`default_nettype wire
